// ===== hdl/ohb_pkg.sv =====
// Package for the overwriting ring history buffer.
// Holds the command type, function codes and field widths shared by the modules that import it.
// No dependencies.
`default_nettype none

package ohb_pkg;

    // Default ring geometry.
    localparam int DEF_DEPTH        = 64;
    localparam int DEF_ELEMENT_BITS = 32;
    localparam int MAX_ELEMENT_BITS = 64;

    // Field widths fixed by the stream format.
    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Command queue between the front and back parts; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Function codes carried on the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  entry_data;
        logic [COUNT_W-1:0] read_count;
    } cmd_t;

    typedef enum logic {
        B_IDLE,
        B_READ
    } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/ohb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// The read register only updates when a read is enabled. No dependencies.
`default_nettype none

module ohb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ohb_front.sv =====
// Front part: decodes the function code of each accepted item into a command
// and holds it in a short queue for the back part. Depends on ohb_pkg.
`default_nettype none

module ohb_front
    import ohb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [DATA_W-1:0]  entry_data,
    input  wire logic [COUNT_W-1:0] read_count,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  wire logic               cmd_pop
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int USED_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [USED_W-1:0] used_reg, used_next;
    cmd_t              new_cmd;
    logic              push;
    logic              pop;

    always_comb begin
        new_cmd.entry_data = entry_data;
        new_cmd.read_count = read_count;
        case (func)
            FUNC_WRITE: new_cmd.op = OP_WRITE;
            FUNC_READ:  new_cmd.op = OP_READ;
            FUNC_CLEAR: new_cmd.op = OP_CLEAR;
            default:    new_cmd.op = OP_NOP;
        endcase
    end

    assign s_ready   = (used_reg != USED_W'(QUEUE_DEPTH));
    assign cmd_valid = (used_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        used_next   = used_reg + USED_W'(push) - USED_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ohb_back.sv =====
// Back part: owns the ring state and storage, carries out queued commands
// and drives the result register. Depends on ohb_pkg and ohb_ram.
`default_nettype none

module ohb_back
    import ohb_pkg::*;
#(
    parameter int DEPTH        = DEF_DEPTH,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output logic                    cmd_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [DATA_W-1:0]       out_data,
    output logic                    has_data,
    output logic                    out_last,
    output logic [COUNT_W-1:0]      fill_count
);

    localparam int HEAD_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    back_state_t state_reg, state_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [HEAD_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_has_reg, out_has_next;
    logic               out_last_reg, out_last_next;
    logic [COUNT_W-1:0] out_fill_reg, out_fill_next;

    logic                        ram_wr_en;
    logic                        ram_rd_en;
    logic [ELEMENT_BITS-1:0]     ram_wr_data;
    logic [ELEMENT_BITS-1:0]     ram_rd_data;
    logic [MAX_ELEMENT_BITS-1:0] entry_wide;
    logic [MAX_ELEMENT_BITS-1:0] rd_wide;

    logic              out_free;
    logic              status_ok;
    logic              issue_ok;
    logic              status_emit;
    logic [CNT_W-1:0]  status_fill;
    logic [CNT_W-1:0]  eff_count;
    logic              cap_ok;

    assign entry_wide  = MAX_ELEMENT_BITS'(cmd.entry_data);
    assign ram_wr_data = entry_wide[ELEMENT_BITS-1:0];
    assign rd_wide     = MAX_ELEMENT_BITS'(ram_rd_data);

    ohb_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (head_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_valid_reg || m_ready;
    assign status_ok = !pend_reg && out_free;
    assign issue_ok  = !pend_reg || out_free;

    // A count of zero, or any count beyond the fill, reads everything stored.
    always_comb begin
        if (cmd.read_count == '0 || cmd.read_count > COUNT_W'(count_reg)) begin
            eff_count = count_reg;
        end else begin
            eff_count = CNT_W'(cmd.read_count);
        end
    end

    assign cap_ok = (cfg_wr_data != '0) && (cfg_wr_data <= COUNT_W'(DEPTH));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid && cmd.op == OP_READ && eff_count != '0) begin
                    state_next = B_READ;
                end
            end
            B_READ: begin
                if (issue_ok && remain_reg == CNT_W'(1)) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        slot_next      = slot_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_fill_next  = out_fill_reg;
        cmd_pop        = 1'b0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        status_emit    = 1'b0;
        status_fill    = count_reg;

        // Read data waiting at the RAM output moves into the result register.
        if (pend_reg && out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = rd_wide[DATA_W-1:0];
            out_has_next   = 1'b1;
            out_last_next  = pend_last_reg;
            out_fill_next  = COUNT_W'(count_reg);
            pend_next      = 1'b0;
        end

        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.op)
                        OP_WRITE: begin
                            if (status_ok) begin
                                ram_wr_en = 1'b1;
                                if (CNT_W'(head_reg) + CNT_W'(1) == cap_reg) begin
                                    head_next = '0;
                                end else begin
                                    head_next = head_reg + HEAD_W'(1);
                                end
                                if (count_reg < cap_reg) begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                                status_emit = 1'b1;
                                status_fill = count_next;
                                cmd_pop     = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            if (status_ok) begin
                                head_next   = '0;
                                count_next  = '0;
                                status_emit = 1'b1;
                                status_fill = '0;
                                cmd_pop     = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (eff_count == '0) begin
                                if (status_ok) begin
                                    status_emit = 1'b1;
                                    cmd_pop     = 1'b1;
                                end
                            end else begin
                                // Oldest entry is at the head once the ring has wrapped.
                                slot_next   = (count_reg < cap_reg) ? '0 : head_reg;
                                remain_next = eff_count;
                                cmd_pop     = 1'b1;
                            end
                        end
                        default: begin
                            if (status_ok) begin
                                status_emit = 1'b1;
                                cmd_pop     = 1'b1;
                            end
                        end
                    endcase
                end
            end
            B_READ: begin
                if (issue_ok) begin
                    ram_rd_en      = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (remain_reg == CNT_W'(1));
                    remain_next    = remain_reg - CNT_W'(1);
                    if (CNT_W'(slot_reg) + CNT_W'(1) >= cap_reg) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + HEAD_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        if (status_emit) begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_has_next   = 1'b0;
            out_last_next  = 1'b1;
            out_fill_next  = COUNT_W'(status_fill);
        end

        // Capacity writes must come only while idle, which the block does not enforce; a valid one empties the ring.
        if (cfg_wr_en && cap_ok) begin
            cap_next   = CNT_W'(cfg_wr_data);
            head_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            slot_reg      <= '0;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            slot_reg      <= slot_next;
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
        out_fill_reg <= out_fill_next;
    end

    assign m_valid    = out_valid_reg;
    assign out_data   = out_data_reg;
    assign has_data   = out_has_reg;
    assign out_last   = out_last_reg;
    assign fill_count = out_fill_reg;

    // The fill never exceeds the capacity and the head stays inside it.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= cap_reg)
        else $error("fill count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(head_reg) < cap_reg)
        else $error("head slot outside capacity");
    // While reading, at least one entry is still to be fetched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_READ) |-> (remain_reg != '0))
        else $error("read sequencer running with nothing left");
    // An issued RAM read leaves data waiting for the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |=> pend_reg)
        else $error("issued read lost");
    // A stalled read result is never dropped by a status result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !out_free) |=> pend_reg)
        else $error("pending read data overwritten");

endmodule

`default_nettype wire

// ===== hdl/overwrite_ring_history_buffer.sv =====
// Top level of the overwriting ring history buffer: front decode and queue,
// back execution unit with the ring RAM. Depends on ohb_pkg, ohb_front, ohb_back.
//
//  Channel   Direction  Content (low bit first)
//  s_axis    in         tuser: func; tdata: entry_data, read_count, pad
//  m_axis    out        tuser: has_data; tlast: last; tdata: out_data, fill_count, pad
//  cfg       in         cfg_wr_data: capacity_in_use, taken when cfg_wr_en is high
//
// A write, clear or unused code is carried out by the back part straight from idle, so
// writes stream at one per cycle while the result register is free. A read first sets
// up its start slot and count, then issues one RAM read per entry; the single read port
// of the ring RAM sets the rate of one entry per cycle unless m_axis_tready stalls.
// Reset is synchronous and active low; it empties the ring and sets the capacity to
// DEPTH. The ring RAM is not cleared, as only written slots are ever read.
// The input and result sides stall on their own: a two-entry command queue lets
// items be accepted while the result register waits on m_axis_tready.
`default_nettype none

module overwrite_ring_history_buffer
    import ohb_pkg::*;
#(
    parameter int DEPTH        = DEF_DEPTH,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Capacity register write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic [COUNT_W-1:0]   cfg_wr_data,
    // Input items.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // entry_data[31:0], read_count[38:32]
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,  // func[1:0]
    // Result items.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // out_data[31:0], fill_count[38:32]
    output logic [0:0]                m_axis_tuser,  // has_data[0]
    output logic                      m_axis_tlast
);

    cmd_t               cmd;
    logic               cmd_valid;
    logic               cmd_pop;
    logic [DATA_W-1:0]  out_data;
    logic               has_data;
    logic [COUNT_W-1:0] fill_count;

    // The front part only decodes and queues; it never looks at ring state.
    ohb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .func       (s_axis_tuser),
        .entry_data (s_axis_tdata[DATA_W-1:0]),
        .read_count (s_axis_tdata[DATA_W+COUNT_W-1:DATA_W]),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // The back part holds head, fill count, capacity and the ring storage.
    ohb_back #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .out_data    (out_data),
        .has_data    (has_data),
        .out_last    (m_axis_tlast),
        .fill_count  (fill_count)
    );

    // Pack the result fields; the top bit is padding to a whole byte.
    assign m_axis_tdata = {{(M_TDATA_W - DATA_W - COUNT_W){1'b0}}, fill_count, out_data};
    assign m_axis_tuser = has_data;

endmodule

`default_nettype wire

// ===== bench/ohb_checker.sv =====
// Scoreboard for the overwriting ring history buffer: follows every request and
// capacity write, predicts the result stream and compares it field by field.
// Depends on ohb_pkg for field widths and operation codes.
module ohb_checker
    import ohb_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [COUNT_W-1:0]   cfg_wr_data,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [0:0]           m_axis_tuser,
    input  wire logic                 m_axis_tlast,
    output int                        fail_count,
    output int                        outstanding,
    output int                        checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               has_data;
        logic               last;
        logic [COUNT_W-1:0] fill;
    } ring_result_t;

    // Shadow copy of the ring and its pointers.
    logic [DATA_W-1:0]  shadow_ring [DEPTH];
    logic [COUNT_W-1:0] shadow_head;
    logic [COUNT_W-1:0] shadow_fill;
    logic [COUNT_W-1:0] shadow_cap;
    ring_result_t       expected_results [$];

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        checked_count = 0;
    end

    function automatic void queue_result(logic [DATA_W-1:0] value, logic valid_entry,
                                         logic final_one);
        ring_result_t r;
        r.data     = value;
        r.has_data = valid_entry;
        r.last     = final_one;
        r.fill     = shadow_fill;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(op_t op, logic [DATA_W-1:0] value,
                                            logic [COUNT_W-1:0] want);
        int n;
        int slot;
        case (op)
            OP_WRITE: begin
                shadow_ring[shadow_head] = value;
                shadow_head = (shadow_head + 1 == shadow_cap) ? '0 : shadow_head + 1;
                if (shadow_fill < shadow_cap) begin
                    shadow_fill = shadow_fill + 1;
                end
                queue_result('0, 1'b0, 1'b1);
            end
            OP_CLEAR: begin
                shadow_head = '0;
                shadow_fill = '0;
                queue_result('0, 1'b0, 1'b1);
            end
            OP_READ: begin
                // A count of zero or any count past the fill level means the whole history.
                n = (want == 0 || want > shadow_fill) ? int'(shadow_fill) : int'(want);
                if (n == 0) begin
                    queue_result('0, 1'b0, 1'b1);
                end else begin
                    // Oldest entry is at the head only once the ring has wrapped.
                    slot = (shadow_fill < shadow_cap) ? 0 : int'(shadow_head);
                    for (int k = 0; k < n; k++) begin
                        queue_result(shadow_ring[slot], 1'b1, k == n - 1);
                        slot = (slot + 1 >= shadow_cap) ? 0 : slot + 1;
                    end
                end
            end
            default: begin
                queue_result('0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic bit field_ok(string field, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
        return want == got;
    endfunction

    always @(posedge aclk) begin
        ring_result_t want;
        bit           good;
        if (!aresetn) begin
            shadow_head = '0;
            shadow_fill = '0;
            shadow_cap  = COUNT_W'(DEPTH);
            expected_results.delete();
        end else begin
            // Out-of-range capacities are dropped and leave the ring intact.
            if (cfg_wr_en && cfg_wr_data != 0 && cfg_wr_data <= DEPTH) begin
                shadow_cap  = cfg_wr_data;
                shadow_head = '0;
                shadow_fill = '0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(op_t'(s_axis_tuser), s_axis_tdata[DATA_W-1:0],
                                s_axis_tdata[DATA_W +: COUNT_W]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                checked_count++;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, expected none, got 0x%0h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    good = field_ok("out_data", want.data, m_axis_tdata[DATA_W-1:0]);
                    good &= field_ok("has_data", want.has_data, m_axis_tuser[0]);
                    good &= field_ok("last", want.last, m_axis_tlast);
                    good &= field_ok("fill_count", want.fill, m_axis_tdata[DATA_W +: COUNT_W]);
                    if (!good) begin
                        fail_count++;
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the ring history buffer bench: clock, reset, request and capacity
// stimulus, result-side backpressure, watchdog and the final verdict.
// Depends on ohb_pkg, the buffer RTL and bench/ohb_checker.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ohb_pkg::*;

    localparam int IDLE_PCT       = 22;    // chance per cycle that a side holds off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 8;     // extra wait after the final drain
    localparam int RANDOM_TARGET  = 360;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [FUNC_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    int fail_count;
    int outstanding;
    int checked_count;

    // While this is set neither side idles, so the block runs at full rate.
    bit steady = 1'b0;

    int requests_sent  = 0;
    int writes_sent    = 0;
    int reads_sent     = 0;
    int clears_sent    = 0;
    int unused_sent    = 0;
    int capacity_sets  = 0;
    int quiet_cycles   = 0;

    always #4 aclk = ~aclk;

    overwrite_ring_history_buffer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ohb_checker ring_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    // The result side stalls at random, one decision per cycle, changed on the
    // falling edge so the block sees a settled tready at the rising edge.
    always @(negedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Any accepted request, result or capacity write counts as progress. A long
    // stretch without any of them means the block has hung.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles, %0d results still due",
                     $time, WATCHDOG_LIMIT, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Every task below starts and ends just after a falling edge. A request keeps
    // tvalid high into the next one unless a random hold-off is drawn, so
    // back-to-back requests never see tvalid dip.
    task automatic send_request(op_t op, logic [DATA_W-1:0] value, logic [COUNT_W-1:0] want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tuser  = op;
        s_axis_tdata  = {1'b0, want, value};
        s_axis_tvalid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        @(negedge aclk);
        requests_sent++;
        case (op)
            OP_WRITE: writes_sent++;
            OP_READ:  reads_sent++;
            OP_CLEAR: clears_sent++;
            default:  unused_sent++;
        endcase
    endtask

    // Stops sending and waits until every predicted result has come out.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    // The capacity register is only touched with the block idle. Every request
    // yields at least one result, so an empty prediction queue means idle.
    task automatic set_capacity(logic [COUNT_W-1:0] value);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        capacity_sets++;
    endtask

    // Read counts cluster around "everything" and small windows, with some past
    // the fill level and some past the largest capacity.
    function automatic logic [COUNT_W-1:0] pick_read_count();
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3, 4, 5: return COUNT_W'($urandom_range(1, DEF_DEPTH));
            6:       return COUNT_W'($urandom_range(DEF_DEPTH + 1, 127));
            7:       return COUNT_W'(DEF_DEPTH);
            default: return COUNT_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_entry();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // A log stream: mostly writes with random content, reads scattered in, and
    // a few clears and unused codes as noise.
    task automatic run_phase(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                send_request(OP_WRITE, pick_entry(), COUNT_W'($urandom));
            end else if (pick < 90) begin
                send_request(OP_READ, $urandom, pick_read_count());
            end else if (pick < 95) begin
                send_request(OP_NOP, $urandom, COUNT_W'($urandom));
            end else begin
                send_request(OP_CLEAR, $urandom, COUNT_W'($urandom));
            end
        end
    endtask

    initial begin
        int phase;
        int directed_total;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset capacity of 64: empty-ring status, the
        // unused code, a clear with nothing stored, data extremes, then reads of
        // everything, a window, a count past the fill level and an exact 64.
        send_request(OP_READ,  '0, '0);
        send_request(OP_NOP,   '1, '1);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_WRITE, 32'h0000_0000, '0);
        send_request(OP_WRITE, 32'hFFFF_FFFF, '1);
        send_request(OP_WRITE, 32'hA5A5_A5A5, '0);
        send_request(OP_WRITE, 32'h5A5A_5A5A, '0);
        send_request(OP_READ,  '0, '0);
        send_request(OP_READ,  '0, COUNT_W'(2));
        send_request(OP_READ,  '1, COUNT_W'(127));
        send_request(OP_READ,  '0, COUNT_W'(DEF_DEPTH));
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_READ,  '0, COUNT_W'(1));

        // Smallest ring: the second write overwrites the first.
        set_capacity(COUNT_W'(1));
        send_request(OP_WRITE, 32'h1234_5678, '0);
        send_request(OP_WRITE, 32'h8765_4321, '0);
        send_request(OP_READ,  '0, '0);
        send_request(OP_READ,  '0, COUNT_W'(1));

        // A ring of three that wraps, so the readout starts at the head.
        set_capacity(COUNT_W'(3));
        for (int i = 0; i < 5; i++) begin
            send_request(OP_WRITE, 32'hC0DE_0000 + i, '0);
        end
        send_request(OP_READ, '0, '0);
        send_request(OP_READ, '0, COUNT_W'(2));

        // Out-of-range capacities must be ignored and leave the ring as it was.
        set_capacity(COUNT_W'(0));
        set_capacity(COUNT_W'(DEF_DEPTH + 1));
        set_capacity(COUNT_W'(127));
        send_request(OP_READ, '0, '0);
        directed_total = requests_sent;

        // Random phases. The first runs the largest ring at full rate on both
        // sides long enough to fill it and overwrite; later ones change the
        // capacity between phases, sometimes to an invalid value.
        phase = 0;
        while (requests_sent < directed_total + RANDOM_TARGET) begin
            if (phase == 0) begin
                set_capacity(COUNT_W'(DEF_DEPTH));
                steady = 1'b1;
                run_phase(150);
                drain();
                steady = 1'b0;
            end else begin
                case ($urandom_range(5))
                    0:       set_capacity(COUNT_W'(DEF_DEPTH));
                    1:       set_capacity(COUNT_W'(1));
                    2:       set_capacity(COUNT_W'(2));
                    3, 4:    set_capacity(COUNT_W'($urandom_range(3, DEF_DEPTH - 1)));
                    default: set_capacity($urandom_range(1) ? COUNT_W'(0)
                                          : COUNT_W'($urandom_range(DEF_DEPTH + 1, 127)));
                endcase
                run_phase($urandom_range(20, 90));
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (%0d writes, %0d reads, %0d clears, %0d unused codes), %0d results checked.",
                 requests_sent, writes_sent, reads_sent, clears_sent, unused_sent, checked_count);
        $display("Capacity written %0d times over %0d phases, including 1, 64 and invalid values.",
                 capacity_sets, phase);
        if (outstanding != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time, outstanding);
        end
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
